// ----- sv/lfs_pkg.sv -----
// Shared types and constants for the line follower steering block.
// Used by line_follower_steering and its port checker; depends on nothing.
package lfs_pkg;

    localparam int unsigned SensorW = 8;
    localparam int unsigned SpeedW  = 9;
    localparam int unsigned TurnW   = 7;
    localparam int unsigned OffW    = 8;
    localparam int unsigned LostW   = 8;
    localparam int unsigned CntW    = 4;
    localparam int unsigned CfgW    = 9;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [SpeedW-1:0] BaseMin   = 9'd70;
    localparam logic [SpeedW-1:0] BaseMax   = 9'd300;
    localparam logic [SpeedW-1:0] WheelMax  = 9'd300;
    localparam logic [SpeedW-1:0] EmergCut  = 9'd10;
    localparam logic [LostW-1:0]  LostSat   = 8'hFF;

    localparam logic [SpeedW-1:0] CruiseRst  = 9'd140;
    localparam logic [LostW-1:0]  LostStopRst = 8'd15;
    localparam logic [CntW-1:0]   ConfirmRst = 4'd2;
    localparam logic [SpeedW-1:0] LostSpdRst = 9'd80;
    localparam logic [TurnW-1:0]  CurveRst   = 7'd12;
    localparam logic [TurnW-1:0]  NormalRst  = 7'd27;
    localparam logic [TurnW-1:0]  EmergRst   = 7'd50;

    typedef enum logic [2:0] {
        MODE_CENTER = 3'd0,
        MODE_LEFT   = 3'd1,
        MODE_RIGHT  = 3'd2,
        MODE_ELEFT  = 3'd3,
        MODE_ERIGHT = 3'd4
    } mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CRUISE_SPEED    = 3'd0,
        REG_LOST_STOP_TICKS = 3'd1,
        REG_CONFIRM_TICKS   = 3'd2,
        REG_LOST_SPEED      = 3'd3,
        REG_CURVE_BIAS      = 3'd4,
        REG_NORMAL_TURN     = 3'd5,
        REG_EMERGENCY_TURN  = 3'd6,
        REG_STEER_INVERT    = 3'd7
    } cfg_idx_t;

endpackage

// ----- sv/line_follower_steering.sv -----
// Line follower differential steering: sensor word in, wheel speed word out.
// Depends on lfs_pkg for mode codes, register indexes and speed limits.
//
// Usage:
//   The s_ channel carries one eight-bit sensor sample per word; the m_
//   channel returns one result word per sample: both wheel speeds in tenths,
//   the lost flag, the tracking mode and the signed turn offset.
//   A word accepted on s_ is on m_ in the cycle after it is taken.
//   Throughput is one word per cycle while m_ready is high. The whole decision
//   (priority encode, confirmation counter, offset select, saturating wheel sums) is one pass
//   of logic from the accepted sample into the result register.
//   s_ready is high while the result register is empty or is being taken,
//   so a stalled receiver holds the current result and blocks at most one
//   further sample.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register
//   per cycle; the user writes only while no word is in flight (unchecked).
//   Reset (aresetn low, synchronous) empties the result register, restores
//   the register defaults and puts the tracker in center mode with cleared
//   counters.
module line_follower_steering (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lfs_pkg::SensorW-1:0]  s_sensor_bits,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lfs_pkg::SpeedW-1:0]   m_left_speed,
    output logic [lfs_pkg::SpeedW-1:0]   m_right_speed,
    output logic                         m_line_lost,
    output logic [2:0]                   m_track_mode,
    output logic signed [lfs_pkg::OffW-1:0] m_steer_offset,
    input  logic                         cfg_we,
    input  logic [lfs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [lfs_pkg::CfgW-1:0]     cfg_data
);
    import lfs_pkg::*;

    // Configuration registers.
    logic [SpeedW-1:0] cruise_speed_reg;
    logic [LostW-1:0]  lost_stop_ticks_reg;
    logic [CntW-1:0]   confirm_ticks_reg;
    logic [SpeedW-1:0] lost_speed_reg;
    logic [TurnW-1:0]  curve_bias_reg;
    logic [TurnW-1:0]  normal_turn_reg;
    logic [TurnW-1:0]  emergency_turn_reg;
    logic              steer_invert_reg;

    // Tracker state.
    mode_t             active_mode_reg, active_mode_next;
    mode_t             candidate_mode_reg, candidate_mode_next;
    logic [CntW-1:0]   confirm_count_reg, confirm_count_next;
    logic [LostW-1:0]  lost_count_reg, lost_count_next;

    // Result register.
    logic                     m_valid_reg;
    logic [SpeedW-1:0]        left_speed_reg, left_speed_next;
    logic [SpeedW-1:0]        right_speed_reg, right_speed_next;
    logic                     line_lost_reg, line_lost_next;
    mode_t                    track_mode_reg, track_mode_next;
    logic signed [OffW-1:0]   steer_offset_reg, steer_offset_next;

    logic                     accept;
    logic                     lost;
    mode_t                    det_mode;
    logic [CntW-1:0]          count_upd;
    logic [SpeedW-1:0]        base_clamped;
    logic [SpeedW-1:0]        base_cut;
    logic [SpeedW-1:0]        base_speed;
    logic [SpeedW-1:0]        lost_wheel;
    logic signed [OffW-1:0]   turn;
    logic signed [OffW-1:0]   applied;
    logic signed [10:0]       base_s;
    logic signed [10:0]       applied_s;
    logic signed [10:0]       left_sum;
    logic signed [10:0]       right_sum;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign lost    = (s_sensor_bits == '0);

    // Priority encoder: outer sensors first, then the inner pairs.
    always_comb begin
        if (s_sensor_bits[0]) begin
            det_mode = MODE_ELEFT;
        end else if (s_sensor_bits[7]) begin
            det_mode = MODE_ERIGHT;
        end else if (s_sensor_bits[1] || s_sensor_bits[2]) begin
            det_mode = MODE_LEFT;
        end else if (s_sensor_bits[5] || s_sensor_bits[6]) begin
            det_mode = MODE_RIGHT;
        end else begin
            det_mode = MODE_CENTER;
        end
    end

    // Mode tracking and the lost counter.
    always_comb begin
        active_mode_next    = active_mode_reg;
        candidate_mode_next = candidate_mode_reg;
        confirm_count_next  = confirm_count_reg;
        lost_count_next     = '0;
        count_upd           = confirm_count_reg;
        if (lost) begin
            lost_count_next     = (lost_count_reg == LostSat) ? LostSat
                                                               : lost_count_reg + 1'b1;
            active_mode_next    = MODE_CENTER;
            candidate_mode_next = MODE_CENTER;
            confirm_count_next  = '0;
        end else if (det_mode == MODE_LEFT || det_mode == MODE_RIGHT) begin
            if (det_mode != candidate_mode_reg) begin
                count_upd = CntW'(1);
            end else if (confirm_count_reg < confirm_ticks_reg) begin
                count_upd = confirm_count_reg + 1'b1;
            end
            candidate_mode_next = det_mode;
            confirm_count_next  = count_upd;
            if (count_upd >= confirm_ticks_reg) begin
                active_mode_next = det_mode;
            end
        end else begin
            active_mode_next    = det_mode;
            candidate_mode_next = det_mode;
            confirm_count_next  = '0;
        end
    end

    // Speeds and offset for the mode that is in effect after this sample.
    always_comb begin
        if (cruise_speed_reg < BaseMin) begin
            base_clamped = BaseMin;
        end else if (cruise_speed_reg > BaseMax) begin
            base_clamped = BaseMax;
        end else begin
            base_clamped = cruise_speed_reg;
        end
        // The clamped base is at least the minimum, so the cut cannot wrap.
        base_cut = base_clamped - EmergCut;
        if (base_cut < BaseMin) begin
            base_cut = BaseMin;
        end

        case (active_mode_next)
            MODE_LEFT: begin
                turn       = signed'({1'b0, normal_turn_reg});
                base_speed = base_clamped;
            end
            MODE_RIGHT: begin
                turn       = -signed'({1'b0, normal_turn_reg});
                base_speed = base_clamped;
            end
            MODE_ELEFT: begin
                turn       = signed'({1'b0, emergency_turn_reg});
                base_speed = base_cut;
            end
            MODE_ERIGHT: begin
                turn       = -signed'({1'b0, emergency_turn_reg});
                base_speed = base_cut;
            end
            default: begin
                turn       = -signed'({1'b0, curve_bias_reg});
                base_speed = base_clamped;
            end
        endcase

        applied   = steer_invert_reg ? -turn : turn;
        base_s    = signed'({2'b00, base_speed});
        applied_s = {{3{applied[OffW-1]}}, applied};
        left_sum  = base_s - applied_s;
        right_sum = base_s + applied_s;

        lost_wheel = (lost_speed_reg > WheelMax) ? WheelMax : lost_speed_reg;

        if (lost) begin
            left_speed_next   = (lost_count_next >= lost_stop_ticks_reg) ? '0 : lost_wheel;
            right_speed_next  = left_speed_next;
            line_lost_next    = 1'b1;
            track_mode_next   = MODE_CENTER;
            steer_offset_next = '0;
        end else begin
            if (left_sum < 0) begin
                left_speed_next = '0;
            end else if (left_sum > signed'({2'b00, WheelMax})) begin
                left_speed_next = WheelMax;
            end else begin
                left_speed_next = left_sum[SpeedW-1:0];
            end
            if (right_sum < 0) begin
                right_speed_next = '0;
            end else if (right_sum > signed'({2'b00, WheelMax})) begin
                right_speed_next = WheelMax;
            end else begin
                right_speed_next = right_sum[SpeedW-1:0];
            end
            line_lost_next    = 1'b0;
            track_mode_next   = active_mode_next;
            steer_offset_next = turn;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_speed_reg    <= CruiseRst;
            lost_stop_ticks_reg <= LostStopRst;
            confirm_ticks_reg   <= ConfirmRst;
            lost_speed_reg      <= LostSpdRst;
            curve_bias_reg      <= CurveRst;
            normal_turn_reg     <= NormalRst;
            emergency_turn_reg  <= EmergRst;
            steer_invert_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_CRUISE_SPEED:    cruise_speed_reg    <= cfg_data;
                REG_LOST_STOP_TICKS: lost_stop_ticks_reg <= cfg_data[LostW-1:0];
                REG_CONFIRM_TICKS:   confirm_ticks_reg   <= cfg_data[CntW-1:0];
                REG_LOST_SPEED:      lost_speed_reg      <= cfg_data;
                REG_CURVE_BIAS:      curve_bias_reg      <= cfg_data[TurnW-1:0];
                REG_NORMAL_TURN:     normal_turn_reg     <= cfg_data[TurnW-1:0];
                REG_EMERGENCY_TURN:  emergency_turn_reg  <= cfg_data[TurnW-1:0];
                REG_STEER_INVERT:    steer_invert_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Tracker state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mode_reg    <= MODE_CENTER;
            candidate_mode_reg <= MODE_CENTER;
            confirm_count_reg  <= '0;
            lost_count_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (accept) begin
                active_mode_reg    <= active_mode_next;
                candidate_mode_reg <= candidate_mode_next;
                confirm_count_reg  <= confirm_count_next;
                lost_count_reg     <= lost_count_next;
                m_valid_reg        <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            left_speed_reg   <= left_speed_next;
            right_speed_reg  <= right_speed_next;
            line_lost_reg    <= line_lost_next;
            track_mode_reg   <= track_mode_next;
            steer_offset_reg <= steer_offset_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_speed   = left_speed_reg;
    assign m_right_speed  = right_speed_reg;
    assign m_line_lost    = line_lost_reg;
    assign m_track_mode   = track_mode_reg;
    assign m_steer_offset = steer_offset_reg;

endmodule

// ----- sv/lfs_port_checker.sv -----
// Port-level checks for line_follower_steering, attached with a bind.
// Depends on lfs_pkg for the mode codes and the wheel limit.
module lfs_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lfs_pkg::SpeedW-1:0]      m_left_speed,
    input logic [lfs_pkg::SpeedW-1:0]      m_right_speed,
    input logic                            m_line_lost,
    input logic [2:0]                      m_track_mode,
    input logic signed [lfs_pkg::OffW-1:0] m_steer_offset
);
    import lfs_pkg::*;

    // A result word that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_speed)
            && $stable(m_right_speed) && $stable(m_line_lost)
            && $stable(m_track_mode) && $stable(m_steer_offset))
        else $error("result word changed while stalled");

    // A lost word drives both wheels alike with no offset in center mode.
    a_lost_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_lost |-> m_left_speed == m_right_speed
            && m_track_mode == MODE_CENTER && m_steer_offset == 0)
        else $error("lost word has inconsistent fields");

    // Wheel speeds stay within the saturation limit.
    a_wheel_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_left_speed <= WheelMax && m_right_speed <= WheelMax)
        else $error("wheel speed above limit");

    // Sample side is never blocked while the result register is empty.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset leaves no result word behind.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind line_follower_steering lfs_port_checker u_lfs_port_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_left_speed   (m_left_speed),
    .m_right_speed  (m_right_speed),
    .m_line_lost    (m_line_lost),
    .m_track_mode   (m_track_mode),
    .m_steer_offset (m_steer_offset)
);
